[rtl/mea_pkg.sv]
`default_nettype none

package mea_pkg;

  localparam int SUM_W        = 44;
  localparam int ERR_W        = 32;
  localparam int MEAN_W       = 32;
  localparam int PAIR_COUNT_W = 13;
  localparam int MAG_W        = 33;
  localparam int SQ_IN_W      = 16;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

  localparam logic MODE_SQUARED  = 1'b0;
  localparam logic MODE_ABSOLUTE = 1'b1;

endpackage

`default_nettype wire

[rtl/mea_intf.sv]
`default_nettype none

interface mea_pair_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] predicted;
  logic [SAMPLE_BITS-1:0] expected;
  logic                   last_pair;

  modport source (output valid, output predicted, output expected, output last_pair,
                  input ready);
  modport sink (input valid, input predicted, input expected, input last_pair,
                output ready);
endinterface

interface mea_result_if;
  import mea_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [MEAN_W-1:0]       mean_error;
  logic [PAIR_COUNT_W-1:0] pair_count;
  logic                    overflow;

  modport source (output valid, output mean_error, output pair_count, output overflow,
                  input ready);
  modport sink (input valid, input mean_error, input pair_count, input overflow,
                output ready);
endinterface

`default_nettype wire

[rtl/mea_front.sv]
`default_nettype none

module mea_front #(
  parameter int  MAX_ELEMENTS = 4096,
  parameter int  SAMPLE_BITS  = 16,
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       error_mode,
  mea_pair_if.sink                        pair,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output logic [mea_pkg::SUM_W-1:0]       push_sum,
  output logic [CNT_W-1:0]                push_count,
  output logic                            push_flag
);
  import mea_pkg::*;

  logic                   s0_valid;
  logic [SAMPLE_BITS-1:0] s0_pred;
  logic [SAMPLE_BITS-1:0] s0_exp;
  logic                   s0_last;
  logic                   s1_valid;
  logic [ERR_W-1:0]       s1_err;
  logic                   s1_last;
  logic [SUM_W-1:0]       sum;
  logic [CNT_W-1:0]       count;
  logic                   flag;

  logic                   stall;
  logic                   advance;
  logic [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]   mag;
  logic [MAG_W-1:0]       magx;
  logic [ERR_W-1:0]       square;
  logic [ERR_W-1:0]       err_next;
  logic [SUM_W:0]         sum_add;
  logic [SUM_W-1:0]       sum_sat;
  logic                   keep;

  assign stall      = s1_valid && s1_last && !push_ready;
  assign advance    = !stall;
  assign pair.ready = advance;

  always_comb begin
    diff   = {s0_pred[SAMPLE_BITS-1], s0_pred} - {s0_exp[SAMPLE_BITS-1], s0_exp};
    mag    = diff[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-diff) : diff;
    magx   = MAG_W'(mag);
    square = ERR_W'(magx[SQ_IN_W-1:0] * magx[SQ_IN_W-1:0]);
    if (error_mode == MODE_ABSOLUTE) begin
      err_next = (|magx[MAG_W-1:ERR_W]) ? ERR_MAX : magx[ERR_W-1:0];
    end else begin
      err_next = (|magx[MAG_W-1:SQ_IN_W]) ? ERR_MAX : square;
    end
  end

  always_comb begin
    sum_add    = {1'b0, sum} + (SUM_W + 1)'(s1_err);
    sum_sat    = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    keep       = count < CNT_W'(MAX_ELEMENTS);
    push_sum   = keep ? sum_sat : sum;
    push_count = keep ? count + CNT_W'(1) : count;
    push_flag  = flag || !keep;
    push_valid = s1_valid && s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      sum      <= '0;
      count    <= '0;
      flag     <= 1'b0;
    end else if (advance) begin
      s0_valid <= pair.valid;
      s1_valid <= s0_valid;
      if (s1_valid) begin
        if (s1_last) begin
          sum   <= '0;
          count <= '0;
          flag  <= 1'b0;
        end else begin
          sum   <= push_sum;
          count <= push_count;
          flag  <= push_flag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_pred <= pair.predicted;
      s0_exp  <= pair.expected;
      s0_last <= pair.last_pair;
      s1_err  <= err_next;
      s1_last <= s0_last;
    end
  end

endmodule

`default_nettype wire

[rtl/mea_queue.sv]
`default_nettype none

module mea_queue #(
  parameter int WIDTH = 62
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int DEPTH  = 2;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem [DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != FILL_W'(DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/mea_back.sv]
`default_nettype none

module mea_back #(
  parameter int  MAX_ELEMENTS = 4096,
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        pop_valid,
  output logic                             pop_ready,
  input  wire logic [mea_pkg::SUM_W-1:0]   pop_sum,
  input  wire logic [CNT_W-1:0]            pop_count,
  input  wire logic                        pop_flag,
  mea_result_if.source                     result
);
  import mea_pkg::*;

  localparam int ITER_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t                          state;
  logic [SUM_W-1:0]                acc;
  logic [CNT_W-1:0]                rem;
  logic [CNT_W-1:0]                divisor;
  logic                            flag;
  logic [ITER_W-1:0]               iter;

  logic [CNT_W:0]                  shifted;
  logic [CNT_W:0]                  trial;
  logic                            ge;
  logic                            fire;
  logic                            emit;
  logic [CNT_W+PAIR_COUNT_W-1:0]   count_ext;

  assign pop_ready = state == ST_IDLE;
  assign fire      = result.valid && result.ready;
  assign emit      = (state == ST_FINISH) && (!result.valid || fire);
  assign count_ext = {PAIR_COUNT_W'(0), divisor};

  always_comb begin
    shifted = {rem, acc[SUM_W-1]};
    trial   = shifted - {1'b0, divisor};
    ge      = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (emit) begin
        result.valid <= 1'b1;
      end else if (fire) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            acc     <= pop_sum;
            rem     <= '0;
            divisor <= pop_count;
            flag    <= pop_flag;
            iter    <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          acc  <= {acc[SUM_W-2:0], ge};
          rem  <= ge ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(SUM_W - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (emit) begin
            result.mean_error <= (divisor == '0) ? '0 : acc[MEAN_W-1:0];
            result.pair_count <= count_ext[PAIR_COUNT_W-1:0];
            result.overflow   <= flag;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/mean_error_accumulator_core.sv]
// Mean squared or mean absolute error over vectors of sample pairs.
// The pair channel carries predicted and expected samples in signed Q4.12
// together with a last_pair flag that closes a vector. The result channel
// carries one item per vector: the truncated mean (Q8.24 for squared error,
// Q4.12 for absolute error), the pair count and an overflow flag that is set
// when pairs beyond MAX_ELEMENTS were dropped. The one-bit error_mode
// register is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Pairs are accepted one per cycle while pair ready is high. A two-stage
// error pipeline feeds the accumulator, and a finished vector goes into a
// two-entry queue. The divider in the back part takes the entry, produces
// one quotient bit per cycle and then loads the output register; it takes
// no new entry until that vector is done. Vectors shorter than about 46
// pairs run at the divider's pace.
// When the result receiver stalls, the result is held, the divider finishes
// the next vector and waits, and the queue fills; the pair channel then
// drops ready only when a last pair finds the queue full.
// Synchronous reset clears the pipeline, the running sum, the queue and the
// output valid flag, and sets error_mode to squared error.
`default_nettype none

module mean_error_accumulator_core #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  mea_pair_if.sink     pair,
  mea_result_if.source result,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);
  import mea_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int REC_W = SUM_W + CNT_W + 1;

  logic             error_mode;
  logic             push_valid;
  logic             push_ready;
  logic [SUM_W-1:0] push_sum;
  logic [CNT_W-1:0] push_count;
  logic             push_flag;
  logic             pop_valid;
  logic             pop_ready;
  logic [REC_W-1:0] pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_mode <= MODE_SQUARED;
    end else if (cfg_we) begin
      error_mode <= cfg_wdata;
    end
  end

  mea_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .error_mode(error_mode),
    .pair      (pair),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_sum  (push_sum),
    .push_count(push_count),
    .push_flag (push_flag)
  );

  mea_queue #(
    .WIDTH(REC_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data ({push_sum, push_count, push_flag}),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  mea_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_sum  (pop_data[REC_W-1:CNT_W+1]),
    .pop_count(pop_data[CNT_W:1]),
    .pop_flag (pop_data[0]),
    .result   (result)
  );

endmodule

`default_nettype wire

[rtl/mea_checker.sv]
`default_nettype none

module mea_checker #(
  parameter int MAX_ELEMENTS = 4096
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             res_valid,
  input wire logic                             res_ready,
  input wire logic [mea_pkg::PAIR_COUNT_W-1:0] res_pair_count,
  input wire logic                             res_overflow
);
  import mea_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result item withdrawn while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result item shown right after reset");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (MAX_ELEMENTS >= (1 << PAIR_COUNT_W)) || (res_pair_count != '0))
    else $error("result item with an empty vector");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_overflow |-> res_pair_count == PAIR_COUNT_W'(MAX_ELEMENTS))
    else $error("overflow reported on a vector that was not full");

endmodule

bind mean_error_accumulator_core mea_checker #(
  .MAX_ELEMENTS(MAX_ELEMENTS)
) u_mea_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_pair_count(result.pair_count),
  .res_overflow  (result.overflow)
);

`default_nettype wire

[bench/mean_error_check.sv]
`timescale 1ns / 1ps

module mean_error_check #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  mea_pair_if       pair,
  mea_result_if     result,
  output int        mismatches,
  output int        mean_pending,
  output int        pairs_taken,
  output int        vectors_done,
  output int        overflow_vectors
);
  import mea_pkg::*;

  typedef struct packed {
    logic [MEAN_W-1:0]       mean;
    logic [PAIR_COUNT_W-1:0] count;
    logic                    overflow;
  } mean_result_t;

  mean_result_t expected_means[$];
  mean_result_t want;
  logic [63:0]  running_sum;
  logic [63:0]  quotient;
  int unsigned  vector_pairs;
  logic         pairs_dropped;
  logic         err_mode;
  int           err_count;
  int           pair_total;
  int           vector_total;
  int           overflow_total;

  function automatic logic [ERR_W-1:0] pair_error(input logic [SAMPLE_BITS-1:0] p,
                                                  input logic [SAMPLE_BITS-1:0] e,
                                                  input logic m);
    longint          diff;
    longint unsigned mag;
    longint unsigned term;
    diff = longint'($signed(p)) - longint'($signed(e));
    mag = (diff < 0) ? longint'(-diff) : longint'(diff);
    if (mag > ERR_MAX) begin
      term = ERR_MAX;
    end else if (m == MODE_SQUARED) begin
      term = mag * mag;
    end else begin
      term = mag;
    end
    if (term > ERR_MAX) begin
      term = ERR_MAX;
    end
    return term[ERR_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_means.delete();
      running_sum = '0;
      vector_pairs = 0;
      pairs_dropped = 1'b0;
      err_mode = MODE_SQUARED;
      err_count = 0;
      pair_total = 0;
      vector_total = 0;
      overflow_total = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_means.size() == 0) begin
          err_count++;
          $display("%0t: result item with none expected (mean_error %0d)", $time,
                   result.mean_error);
        end else begin
          want = expected_means.pop_front();
          if (result.mean_error !== want.mean) begin
            err_count++;
            $display("%0t: mean_error expected %0d, got %0d", $time, want.mean,
                     result.mean_error);
          end
          if (result.pair_count !== want.count) begin
            err_count++;
            $display("%0t: pair_count expected %0d, got %0d", $time, want.count,
                     result.pair_count);
          end
          if (result.overflow !== want.overflow) begin
            err_count++;
            $display("%0t: overflow expected %0b, got %0b", $time, want.overflow,
                     result.overflow);
          end
        end
      end

      if (pair.valid && pair.ready) begin
        pair_total++;
        if (vector_pairs < MAX_ELEMENTS) begin
          running_sum = running_sum + pair_error(pair.predicted, pair.expected, err_mode);
          if (running_sum > SUM_MAX) begin
            running_sum = SUM_MAX;
          end
          vector_pairs++;
        end else begin
          pairs_dropped = 1'b1;
        end
        if (pair.last_pair) begin
          quotient = (vector_pairs == 0) ? 64'd0 : running_sum / vector_pairs;
          want.mean = quotient[MEAN_W-1:0];
          want.count = vector_pairs[PAIR_COUNT_W-1:0];
          want.overflow = pairs_dropped;
          expected_means.push_back(want);
          vector_total++;
          if (pairs_dropped) begin
            overflow_total++;
          end
          running_sum = '0;
          vector_pairs = 0;
          pairs_dropped = 1'b0;
        end
      end

      if (cfg_we) begin
        err_mode = cfg_wdata;
      end
    end

    mismatches <= err_count;
    mean_pending <= expected_means.size();
    pairs_taken <= pair_total;
    vectors_done <= vector_total;
    overflow_vectors <= overflow_total;
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import mea_pkg::*;

  localparam int MAX_ELEMENTS = 4096;
  localparam int SAMPLE_BITS  = 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 600;
  localparam int LONG_VECTOR  = 120;

  localparam logic [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stage = 0;
  logic held_once = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int mode_writes = 0;

  int mismatches;
  int mean_pending;
  int pairs_taken;
  int vectors_done;
  int overflow_vectors;

  mea_pair_if #(.SAMPLE_BITS(SAMPLE_BITS)) pair_ch();
  mea_result_if result_ch();

  mean_error_accumulator_core #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pair     (pair_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  mean_error_check #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) mean_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .pair            (pair_ch),
    .result          (result_ch),
    .mismatches      (mismatches),
    .mean_pending    (mean_pending),
    .pairs_taken     (pairs_taken),
    .vectors_done    (vectors_done),
    .overflow_vectors(overflow_vectors)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The result receiver stops taking items for a long stretch once the
  // last stage begins, so the result queue fills and the pair input stalls.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (stage == 2 && !held_once) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(7))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return SAMPLE_BITS'(int'($urandom_range(64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_pair(input logic [SAMPLE_BITS-1:0] p, input logic [SAMPLE_BITS-1:0] e,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      pair_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pair_ch.valid <= 1'b1;
    pair_ch.predicted <= p;
    pair_ch.expected <= e;
    pair_ch.last_pair <= last;
    @(posedge clk);
    while (!pair_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    pair_ch.valid <= 1'b0;
    @(posedge clk);
    while (mean_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_writes++;
  endtask

  task automatic random_vector(inout int sent);
    int unsigned len;
    logic [SAMPLE_BITS-1:0] p;
    case ($urandom_range(19))
      0: len = $urandom_range(120, 47);
      1, 2, 3, 4: len = $urandom_range(46, 9);
      default: len = $urandom_range(8, 1);
    endcase
    for (int unsigned i = 0; i < len; i++) begin
      p = rand_sample();
      send_pair(p, ($urandom_range(9) == 0) ? p : rand_sample(), i == len - 1);
    end
    sent += len;
  endtask

  task automatic run_stage(input int goal);
    int sent;
    sent = 0;
    while (sent < goal) begin
      if ($urandom_range(7) == 0) begin
        write_mode(1'($urandom_range(1)));
      end
      random_vector(sent);
    end
  endtask

  initial begin
    pair_ch.valid = 1'b0;
    pair_ch.predicted = '0;
    pair_ch.expected = '0;
    pair_ch.last_pair = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_mode(MODE_SQUARED);
    send_pair(MOST_POS, MOST_NEG, 1'b1);
    send_pair(MOST_NEG, MOST_POS, 1'b0);
    send_pair('0, '0, 1'b0);
    send_pair(SAMPLE_BITS'(-1), '0, 1'b0);
    send_pair(MOST_POS, MOST_POS, 1'b0);
    send_pair(SAMPLE_BITS'(1), SAMPLE_BITS'(-1), 1'b1);
    send_pair('0, '0, 1'b1);

    write_mode(MODE_ABSOLUTE);
    send_pair(MOST_POS, MOST_NEG, 1'b1);
    send_pair(MOST_NEG, MOST_POS, 1'b0);
    send_pair('0, SAMPLE_BITS'(1), 1'b0);
    send_pair(SAMPLE_BITS'(16'h5555), SAMPLE_BITS'(16'hAAAA), 1'b1);

    // A vector that starts in absolute mode and ends in squared mode.
    send_pair(SAMPLE_BITS'(300), SAMPLE_BITS'(-700), 1'b0);
    send_pair(MOST_NEG, '0, 1'b0);
    write_mode(MODE_SQUARED);
    send_pair(SAMPLE_BITS'(1000), '0, 1'b0);
    send_pair('0, SAMPLE_BITS'(3), 1'b1);

    write_mode(MODE_ABSOLUTE);
    send_idle_pct <= 18;
    recv_idle_pct <= 66;
    run_stage(400);

    write_mode(MODE_SQUARED);
    send_idle_pct <= 66;
    recv_idle_pct <= 18;
    stage <= 1;
    run_stage(400);

    write_mode(MODE_ABSOLUTE);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    stage <= 2;
    run_stage(400);

    // A long vector of the largest squared error.
    write_mode(MODE_SQUARED);
    for (int i = 0; i < LONG_VECTOR; i++) begin
      send_pair(MOST_POS, MOST_NEG, i == LONG_VECTOR - 1);
    end

    settle();
    $display("Sent %0d pairs in %0d vectors; %0d of them reached the %0d-pair limit.",
             pairs_taken, vectors_done, overflow_vectors, MAX_ELEMENTS);
    $display("Mode was written %0d times, under three patterns of idling and stalls.",
             mode_writes);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[mean_error_accumulator_core.f]
rtl/mea_pkg.sv
rtl/mea_intf.sv
rtl/mea_front.sv
rtl/mea_queue.sv
rtl/mea_back.sv
rtl/mean_error_accumulator_core.sv
rtl/mea_checker.sv
bench/mean_error_check.sv
bench/testbench.sv
